// ===== src/ltrr_pkg.sv =====
// Shared constants, codes and types of the label table relocation resolver.
`default_nettype none
package ltrr_pkg;

    localparam int unsigned DEPTH = 256;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned ENT_W  = KEY_W + ADDR_W;

    localparam logic [1:0] CMD_DEFINE = 2'd0;
    localparam logic [1:0] CMD_RES32  = 2'd1;
    localparam logic [1:0] CMD_RES8   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_UNDEFINED = 3'd2;
    localparam logic [2:0] ST_TOO_FAR   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_BLOCKED   = 3'd5;

    localparam logic [2:0] PB_NONE = 3'd0;
    localparam logic [2:0] PB_BYTE = 3'd1;
    localparam logic [2:0] PB_WORD = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ADJ,
        S_DIFF,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] displacement;
        logic [2:0]  patch_bytes;
        logic [31:0] error_label;
    } t_result;

endpackage
`default_nettype wire

// ===== src/ltrr_ifs.sv =====
// Handshake interfaces for the request and result channels.
`default_nettype none
interface ltrr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] label_id;
    logic [63:0] base_address;
    logic [31:0] local_offset;

    modport source (output valid, output command, output label_id,
                    output base_address, output local_offset, input ready);
    modport sink   (input valid, input command, input label_id,
                    input base_address, input local_offset, output ready);
endinterface

interface ltrr_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] displacement;
    logic [2:0]         patch_bytes;
    logic [31:0]        error_label;

    modport source (output valid, output status, output displacement,
                    output patch_bytes, output error_label, input ready);
    modport sink   (input valid, input status, input displacement,
                    input patch_bytes, input error_label, output ready);
endinterface
`default_nettype wire

// ===== src/label_table_relocation_resolver.sv =====
// Top level of the label table relocation resolver.
//
//   Channel   Direction  Carries
//   i_in      sink       command, label_id, base_address, local_offset
//   o_out     source     status, displacement, patch_bytes, error_label
//
// A define or an unblocked resolve walks the label table one entry per cycle
// through the single table memory, visiting at most the n labels stored
// (at most DEPTH). A blocked resolve or an unused command skips the scan
// and goes straight to the result. Reset clears the fill count and the error latch
// at once; the table memory itself is never cleared, since only entries below
// the fill count are ever read. A stalled result sits in the output register
// while the next transaction is already accepted and scanned.
`default_nettype none
module label_table_relocation_resolver (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ltrr_in_if.sink      i_in,
    ltrr_out_if.source   o_out
);

    // Table memory: label key in the upper bits, absolute address below.
    // Entries are filled in order, so an index below the fill count marks a
    // valid entry and no per-entry valid bits are needed.
    logic [ltrr_pkg::ENT_W-1:0] r_mem [ltrr_pkg::DEPTH];
    logic [ltrr_pkg::ENT_W-1:0] r_rd_data;

    ltrr_pkg::t_state         r_state, n_state;
    logic [1:0]               r_cmd, n_cmd;
    logic [31:0]              r_label, n_label;
    logic [63:0]              r_here, n_here;
    logic [63:0]              r_there, n_there;
    logic [63:0]              r_rel, n_rel;
    logic [ltrr_pkg::CNT_W-1:0] r_idx, n_idx;
    logic                     r_rd_vld, n_rd_vld;
    logic [ltrr_pkg::CNT_W-1:0] r_count, n_count;
    logic                     r_latched, n_latched;
    ltrr_pkg::t_result        r_pend, n_pend;
    logic                     r_out_valid, n_out_valid;
    ltrr_pkg::t_result        r_out, n_out;

    logic                     mem_we;
    logic                     in_acc;
    logic                     hit;
    logic                     fits;

    assign i_in.ready = (r_state == ltrr_pkg::S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // A key compare uses the registered read data, in the cycle after its read was issued.
    assign hit = r_rd_vld && (r_rd_data[ltrr_pkg::ENT_W-1:ltrr_pkg::ADDR_W] == r_label);

    // The displacement fits when all bits above the patch's sign bit equal it.
    always_comb begin
        if (r_cmd == ltrr_pkg::CMD_RES32) begin
            fits = (&r_rel[63:31]) || !(|r_rel[63:31]);
        end else begin
            fits = (&r_rel[63:7]) || !(|r_rel[63:7]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_label     = r_label;
        n_here      = r_here;
        n_there     = r_there;
        n_rel       = r_rel;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_count     = r_count;
        n_latched   = r_latched;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ltrr_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_in.command;
                    n_label = i_in.label_id;
                    n_here  = i_in.base_address + {32'd0, i_in.local_offset};
                    n_idx   = '0;
                    n_pend  = '0;
                    unique case (i_in.command) inside
                        ltrr_pkg::CMD_DEFINE: begin
                            n_state = ltrr_pkg::S_SCAN;
                        end
                        ltrr_pkg::CMD_RES32, ltrr_pkg::CMD_RES8: begin
                            if (r_latched) begin
                                n_pend.status = ltrr_pkg::ST_BLOCKED;
                                n_state       = ltrr_pkg::S_EMIT;
                            end else begin
                                n_state = ltrr_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            // Unused command: all-zero result, table and error latch unchanged.
                            n_state = ltrr_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            ltrr_pkg::S_SCAN: begin
                if (hit) begin
                    if (r_cmd == ltrr_pkg::CMD_DEFINE) begin
                        n_pend.status      = ltrr_pkg::ST_DUPLICATE;
                        n_pend.error_label = r_label;
                        n_state            = ltrr_pkg::S_EMIT;
                    end else begin
                        n_there = r_rd_data[ltrr_pkg::ADDR_W-1:0];
                        n_state = ltrr_pkg::S_ADJ;
                    end
                end else if (r_idx == r_count) begin
                    if (r_cmd == ltrr_pkg::CMD_DEFINE) begin
                        if (r_count == ltrr_pkg::CNT_W'(ltrr_pkg::DEPTH)) begin
                            n_pend.status = ltrr_pkg::ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_pend.status      = ltrr_pkg::ST_UNDEFINED;
                        n_pend.error_label = r_label;
                        n_latched          = 1'b1;
                    end
                    n_state = ltrr_pkg::S_EMIT;
                end else begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end
            end
            ltrr_pkg::S_ADJ: begin
                n_here  = r_here + ((r_cmd == ltrr_pkg::CMD_RES32) ? 64'd4 : 64'd1);
                n_state = ltrr_pkg::S_DIFF;
            end
            ltrr_pkg::S_DIFF: begin
                n_rel   = r_there - r_here;
                n_state = ltrr_pkg::S_CHECK;
            end
            ltrr_pkg::S_CHECK: begin
                if (fits) begin
                    n_pend.displacement = r_rel[31:0];
                    n_pend.patch_bytes  = (r_cmd == ltrr_pkg::CMD_RES32)
                                          ? ltrr_pkg::PB_WORD : ltrr_pkg::PB_BYTE;
                end else begin
                    n_pend.status = ltrr_pkg::ST_TOO_FAR;
                    n_latched     = 1'b1;
                end
                n_state = ltrr_pkg::S_EMIT;
            end
            ltrr_pkg::S_EMIT: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ltrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ltrr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ltrr_pkg::S_IDLE;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_latched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_count     <= n_count;
            r_latched   <= n_latched;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_label <= n_label;
        r_here  <= n_here;
        r_there <= n_there;
        r_rel   <= n_rel;
        r_idx   <= n_idx;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    // Table memory: one write port at the fill count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[ltrr_pkg::IDX_W-1:0]] <= {r_label, r_here};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_idx[ltrr_pkg::IDX_W-1:0]];
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.displacement = $signed(r_out.displacement);
    assign o_out.patch_bytes  = r_out.patch_bytes;
    assign o_out.error_label  = r_out.error_label;

`ifndef SYNTHESIS
    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ltrr_pkg::CNT_W'(ltrr_pkg::DEPTH))
        else $error("fill count beyond table depth");

    // The table only grows, and by at most one entry per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ((r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)))
        else $error("fill count moved unexpectedly");

    // A blocked result is only produced once the error latch is set.
    a_blocked_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ltrr_pkg::ST_BLOCKED)) |-> r_latched)
        else $error("blocked result without latched error");

    // A patch size is only reported for a successful resolve.
    a_patch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.patch_bytes != ltrr_pkg::PB_NONE))
            |-> (r_out.status == ltrr_pkg::ST_OK))
        else $error("patch size on a failed transaction");
`endif

endmodule
`default_nettype wire
